@@ hdl/windowed_mean_or_rms_macros.svh @@
// Assertion macros shared by the windowed mean / RMS block.
`ifndef WINDOWED_MEAN_OR_RMS_MACROS_SVH
`define WINDOWED_MEAN_OR_RMS_MACROS_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define WMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and off during reset.
`define WMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/wmr_pkg.sv @@
// Shared types and constants of the windowed mean / RMS block.
package wmr_pkg;

  // Operation codes of an input item.
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RMS_MODE    = 2'd1;

  // Reset value of the window size register.
  localparam int WINDOW_RESET = 16;

  // Controller states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SQOLD = 8'b0000_0010,
    ST_SUB   = 8'b0000_0100,
    ST_ADD   = 8'b0000_1000,
    ST_PREP  = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_SQRT  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } wmr_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take the input item (and clear the window on a clear)
    logic sq_old;     // form the oldest entry's contribution, write the new sample
    logic sub_old;    // drop the oldest contribution or grow the count
    logic add_new;    // add the new sample's contribution
    logic prep;       // set up the divider and root units
    logic div_step;   // one quotient bit
    logic sqrt_step;  // one root bit
    logic out_load;   // move the finished result into the output register
  } wmr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rms;        // active mode is RMS
    logic div_last;   // the current divide step is the last one
    logic sqrt_last;  // the current root step is the last one
    logic out_hold;   // the output register is full and not being taken
  } wmr_stat_t;

endpackage

@@ hdl/wmr_ctrl.sv @@
// Controller state machine that sequences one item through the datapath.
module wmr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_operation,
  output logic               in_ready,
  input  wmr_pkg::wmr_stat_t stat,
  output wmr_pkg::wmr_cmd_t  cmd
);
  import wmr_pkg::*;

  wmr_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_operation == OP_CLEAR) ? ST_DONE : ST_SQOLD;
        end
      end
      ST_SQOLD: begin
        cmd.sq_old = 1'b1;
        state_nxt  = ST_SUB;
      end
      ST_SUB: begin
        cmd.sub_old = 1'b1;
        state_nxt   = ST_ADD;
      end
      ST_ADD: begin
        cmd.add_new = 1'b1;
        state_nxt   = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = stat.rms ? ST_SQRT : ST_DONE;
        end
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (stat.sqrt_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_hold) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/wmr_dp.sv @@
// Datapath: sample ring, running total, serial divider, serial square root
// and output register.
module wmr_dp #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16,
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_operation,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  logic                              cfg_valid,
  input  logic [wmr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [CNT_W-1:0]                  cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic signed [SAMPLE_BITS-1:0]     out_average,
  output logic [CNT_W-1:0]                  out_count,
  input  wmr_pkg::wmr_cmd_t                 cmd,
  output wmr_pkg::wmr_stat_t                stat
);
  import wmr_pkg::*;

  localparam int S      = SAMPLE_BITS;
  localparam int SLOT_W = $clog2(WINDOW_MAX);
  localparam int TOT_W  = 2 * S + CNT_W;
  localparam int STEP_W = $clog2(TOT_W);
  localparam int WIN_RST = (WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET;

  localparam logic [CNT_W-1:0]        WIN_MAX_C  = CNT_W'(WINDOW_MAX);
  localparam logic signed [TOT_W:0]   MEAN_MAX   = (TOT_W + 1)'((1 << (S - 1)) - 1);
  localparam logic signed [TOT_W:0]   MEAN_MIN   = ~MEAN_MAX;
  localparam logic [S-1:0]            ROOT_MAX   = {1'b0, {(S - 1){1'b1}}};

  // Configuration and latched settings.
  logic [CNT_W-1:0]  window_size_r;
  logic              rms_mode_r;
  logic [CNT_W-1:0]  act_size_r;
  logic              act_rms_r;
  logic [CNT_W-1:0]  size_sat;

  // Window state.
  logic signed [TOT_W-1:0] total_r;
  logic [CNT_W-1:0]        fill_r;
  logic [SLOT_W-1:0]       write_slot_r;
  logic [CNT_W-1:0]        slot_inc;
  logic [SLOT_W-1:0]       slot_nxt;
  logic                    full;

  // Item and ring.
  logic                    op_r;
  logic signed [S-1:0]     sample_r;
  logic signed [S-1:0]     ring_q;
  logic [S-1:0]            ring [WINDOW_MAX];

  // Contribution of a sample.
  logic signed [S-1:0]     mul_op;
  logic signed [2*S-1:0]   mul_sq;
  logic signed [TOT_W-1:0] contrib;
  logic signed [TOT_W-1:0] product_r;

  // Divider and root units.
  logic [STEP_W-1:0]       step_r;
  logic [TOT_W-1:0]        q_r;
  logic [CNT_W-1:0]        rem_r;
  logic                    neg_r;
  logic [TOT_W-1:0]        total_abs;
  logic [CNT_W:0]          rem_sh;
  logic                    rem_ge;
  logic [CNT_W:0]          rem_diff;
  logic [S+1:0]            srem_r;
  logic [S-1:0]            root_r;
  logic [S+3:0]            srem_sh;
  logic [S+3:0]            trial;
  logic                    root_ge;
  logic [S+3:0]            srem_diff;

  // Result selection.
  logic signed [TOT_W:0]   mean_val;
  logic signed [TOT_W:0]   mean_sat;
  logic [S-1:0]            root_sat;
  logic signed [S-1:0]     avg_sel;
  logic                    out_valid_r;
  logic signed [S-1:0]     out_average_r;
  logic [CNT_W-1:0]        out_count_r;

  // Window size as latched on a clear: zero counts as one, large values saturate.
  always_comb begin
    if (window_size_r == '0) begin
      size_sat = CNT_W'(1);
    end else if (window_size_r > WIN_MAX_C) begin
      size_sat = WIN_MAX_C;
    end else begin
      size_sat = window_size_r;
    end
  end

  // Slot bookkeeping.
  assign slot_inc = CNT_W'(write_slot_r) + CNT_W'(1);
  assign slot_nxt = (slot_inc >= act_size_r) ? '0 : slot_inc[SLOT_W-1:0];
  assign full     = (fill_r >= act_size_r);

  // Contribution: the sample itself, or its square in RMS mode.
  assign mul_op  = cmd.sq_old ? ring_q : sample_r;
  assign mul_sq  = mul_op * mul_op;
  assign contrib = act_rms_r ? $signed({{(TOT_W - 2 * S){1'b0}}, mul_sq})
                             : $signed({{(TOT_W - S){mul_op[S-1]}}, mul_op});

  // Divider step: restoring, one quotient bit per cycle.
  assign total_abs = total_r[TOT_W-1] ? TOT_W'(-total_r) : TOT_W'(total_r);
  assign rem_sh    = {rem_r, q_r[TOT_W-1]};
  assign rem_ge    = (rem_sh >= {1'b0, fill_r});
  assign rem_diff  = rem_sh - {1'b0, fill_r};

  // Root step: two radicand bits per cycle from the quotient.
  assign srem_sh   = {srem_r, q_r[2*S-1:2*S-2]};
  assign trial     = {2'b00, root_r, 2'b01};
  assign root_ge   = (srem_sh >= trial);
  assign srem_diff = srem_sh - trial;

  // Configuration registers and control state of the window.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= CNT_W'(WIN_RST);
      rms_mode_r    <= 1'b0;
      act_size_r    <= CNT_W'(WIN_RST);
      act_rms_r     <= 1'b0;
      total_r       <= '0;
      fill_r        <= '0;
      write_slot_r  <= '0;
      step_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WINDOW_SIZE: window_size_r <= cfg_data;
          CFG_RMS_MODE:    rms_mode_r    <= cfg_data[0];
          default:         ;
        endcase
      end
      if (cmd.load && (in_operation == OP_CLEAR)) begin
        act_size_r   <= size_sat;
        act_rms_r    <= rms_mode_r;
        total_r      <= '0;
        fill_r       <= '0;
        write_slot_r <= '0;
      end
      if (cmd.sq_old) begin
        write_slot_r <= slot_nxt;
      end
      if (cmd.sub_old) begin
        if (full) begin
          total_r <= total_r - product_r;
        end else begin
          fill_r <= fill_r + CNT_W'(1);
        end
      end
      if (cmd.add_new) begin
        total_r <= total_r + product_r;
      end
      if (cmd.prep) begin
        step_r <= '0;
      end else if (cmd.div_step) begin
        step_r <= stat.div_last ? '0 : step_r + STEP_W'(1);
      end else if (cmd.sqrt_step) begin
        step_r <= step_r + STEP_W'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Sample ring: written at the current slot, read there every cycle.
  always_ff @(posedge clk) begin
    if (cmd.sq_old) begin
      ring[write_slot_r] <= sample_r;
    end
    ring_q <= $signed(ring[write_slot_r]);
  end

  // Item, product and unit payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_operation;
      sample_r <= in_sample;
    end
    if (cmd.sq_old || cmd.sub_old) begin
      product_r <= contrib;
    end
    if (cmd.prep) begin
      q_r    <= total_abs;
      neg_r  <= total_r[TOT_W-1];
      rem_r  <= '0;
      srem_r <= '0;
      root_r <= '0;
    end else if (cmd.div_step) begin
      q_r   <= {q_r[TOT_W-2:0], rem_ge};
      rem_r <= rem_ge ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end else if (cmd.sqrt_step) begin
      q_r    <= {q_r[TOT_W-3:0], 2'b00};
      srem_r <= root_ge ? srem_diff[S+1:0] : srem_sh[S+1:0];
      root_r <= {root_r[S-2:0], root_ge};
    end
    if (cmd.out_load) begin
      out_average_r <= avg_sel;
      out_count_r   <= fill_r;
    end
  end

  // Signed mean with saturation, or saturated root.
  assign mean_val = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  always_comb begin
    if (mean_val > MEAN_MAX) begin
      mean_sat = MEAN_MAX;
    end else if (mean_val < MEAN_MIN) begin
      mean_sat = MEAN_MIN;
    end else begin
      mean_sat = mean_val;
    end
  end
  assign root_sat = (root_r > ROOT_MAX) ? ROOT_MAX : root_r;

  // An empty window after a clear reports zero.
  always_comb begin
    if (op_r == OP_CLEAR) begin
      avg_sel = '0;
    end else if (act_rms_r) begin
      avg_sel = $signed(root_sat);
    end else begin
      avg_sel = mean_sat[S-1:0];
    end
  end

  // Status to the controller.
  assign stat.rms       = act_rms_r;
  assign stat.div_last  = (step_r == STEP_W'(TOT_W - 1));
  assign stat.sqrt_last = (step_r == STEP_W'(S - 1));
  assign stat.out_hold  = out_valid_r && !out_ready;

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;
  assign out_count   = out_count_r;

endmodule

@@ hdl/windowed_mean_or_rms.sv @@
// Top level of the windowed mean / RMS block.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid/in_ready    in_operation, in_sample
//   out_     output     out_valid/out_ready  out_average, out_count
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An add item is accepted and then passes the states SQOLD, SUB, ADD and PREP,
// the one-bit-per-cycle divider and, in RMS mode, the two-bit-per-cycle root
// unit, and waits in DONE until the output register is free. A clear item goes
// from acceptance straight to DONE. One item is in work at a time; the output
// register holds a result while the next item is accepted and worked on. Reset
// is synchronous and needs no clearing pass. cfg_ready is always high.
module windowed_mean_or_rms #(
  parameter int WINDOW_MAX  = 256,
  parameter int SAMPLE_BITS = 16,
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_average,
  output logic [CNT_W-1:0]                  out_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wmr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [CNT_W-1:0]                  cfg_data
);
  import wmr_pkg::*;

  `include "windowed_mean_or_rms_macros.svh"

  wmr_cmd_t  cmd;
  wmr_stat_t stat;

  assign cfg_ready = 1'b1;

  // Sequencer.
  wmr_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  // Ring, total, arithmetic units and output register.
  wmr_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_operation),
    .in_sample    (in_sample),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .out_average  (out_average),
    .out_count    (out_count),
    .cmd          (cmd),
    .stat         (stat)
  );

  // One item in work at a time: an accepted item closes the input.
  `WMR_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted while busy")
  // An empty window reports a zero average.
  `WMR_ASSERT_NOW(a_empty_zero, out_valid && (out_count == '0), out_average == '0, "empty window nonzero")
  // The count never exceeds the largest window.
  `WMR_ASSERT_NOW(a_count_max, out_valid, out_count <= CNT_W'(WINDOW_MAX), "count above window")

endmodule
